/* design/lprd_pkg.sv */
// ----------------------------------------------------------------------------
// lprd_pkg: shared definitions for the length-prefixed record deframer
// Header layout offsets and the packed widths of the result stream.
// ----------------------------------------------------------------------------
package lprd_pkg;

    // Header geometry: 16 bytes, little-endian fields.
    localparam int unsigned HDR_BYTES    = 16;
    localparam int unsigned HDR_POS_W    = $clog2(HDR_BYTES);
    localparam int unsigned OFS_LENGTH   = 2;
    localparam int unsigned OFS_X        = 4;
    localparam int unsigned OFS_Y        = 8;
    localparam int unsigned OFS_Z        = 12;

    // Field widths of one result.
    localparam int unsigned REQ_W   = 16;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 16;

    // Result tdata: request, length, x, y, z, payload byte, payload index.
    localparam int unsigned OUT_TDATA_W =
        REQ_W + LEN_W + 3 * WORD_W + BYTE_W + IDX_W;

    typedef logic [HDR_POS_W-1:0] t_hdr_pos;

    // One result as held in the output register.
    typedef struct packed {
        logic [IDX_W-1:0]  payload_index;
        logic [BYTE_W-1:0] payload_byte;
        logic [WORD_W-1:0] z_bits;
        logic [WORD_W-1:0] y_bits;
        logic [WORD_W-1:0] x_bits;
        logic [LEN_W-1:0]  payload_length;
        logic [REQ_W-1:0]  request_code;
    } t_result_data;

endpackage

/* design/length_prefixed_record_deframer.sv */
// ----------------------------------------------------------------------------
// length_prefixed_record_deframer: byte-stream record splitter
// A result appears on the master side in the cycle after the byte that
// causes it is accepted. Throughput: one byte per cycle while the sink is ready,
// set by the single output register with ready passed back combinationally from the sink.
// Reset (synchronous, active low) returns the block to header collection
// with all header fields and counters cleared.
// ----------------------------------------------------------------------------
module length_prefixed_record_deframer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave side: raw byte stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] data_byte
    // Master side: one result per payload byte or per empty record.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] request_code, [31:16] payload_length, [63:32] x_bits,
    // [95:64] y_bits, [127:96] z_bits, [135:128] payload_byte,
    // [151:136] payload_index
    output logic [lprd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tuser,   // [0] byte_valid
    output logic                                m_axis_tlast    // last
);

    import lprd_pkg::*;

    // Parsing state.
    logic              r_in_payload, n_in_payload;
    t_hdr_pos          r_hdr_pos,    n_hdr_pos;
    logic [IDX_W-1:0]  r_pay_cnt,    n_pay_cnt;
    logic [REQ_W-1:0]  r_request,    n_request;
    logic [LEN_W-1:0]  r_length,     n_length;
    logic [WORD_W-1:0] r_x,          n_x;
    logic [WORD_W-1:0] r_y,          n_y;
    logic [WORD_W-1:0] r_z,          n_z;

    // Output register.
    logic              r_out_valid,  n_out_valid;
    t_result_data      r_out_data,   n_out_data;
    logic              r_out_user,   n_out_user;
    logic              r_out_last,   n_out_last;

    logic              in_accept;
    logic              emit;
    logic              emit_valid;
    logic              emit_last;
    logic [BYTE_W-1:0] emit_byte;
    logic [IDX_W-1:0]  emit_idx;
    logic [IDX_W:0]    idx_plus_one;

    // The output register can take a new request when empty or being drained.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign idx_plus_one  = {1'b0, r_pay_cnt} + 1'b1;

    // Header capture and payload counting.
    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_pos    = r_hdr_pos;
        n_pay_cnt    = r_pay_cnt;
        n_request    = r_request;
        n_length     = r_length;
        n_x          = r_x;
        n_y          = r_y;
        n_z          = r_z;
        emit         = 1'b0;
        emit_valid   = 1'b0;
        emit_last    = 1'b0;
        emit_byte    = '0;
        emit_idx     = '0;
        if (in_accept) begin
            if (!r_in_payload) begin
                // Place the byte into its header field, little-endian.
                if (r_hdr_pos < t_hdr_pos'(OFS_LENGTH)) begin
                    n_request[r_hdr_pos[0]*8 +: 8] = s_axis_tdata;
                end else if (r_hdr_pos < t_hdr_pos'(OFS_X)) begin
                    n_length[r_hdr_pos[0]*8 +: 8] = s_axis_tdata;
                end else if (r_hdr_pos < t_hdr_pos'(OFS_Y)) begin
                    n_x[r_hdr_pos[1:0]*8 +: 8] = s_axis_tdata;
                end else if (r_hdr_pos < t_hdr_pos'(OFS_Z)) begin
                    n_y[r_hdr_pos[1:0]*8 +: 8] = s_axis_tdata;
                end else begin
                    n_z[r_hdr_pos[1:0]*8 +: 8] = s_axis_tdata;
                end
                if (r_hdr_pos != t_hdr_pos'(HDR_BYTES - 1)) begin
                    n_hdr_pos = r_hdr_pos + 1'b1;
                end else begin
                    // Header complete: an empty record reports at once.
                    n_hdr_pos = '0;
                    n_pay_cnt = '0;
                    if (n_length == '0) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                    end else begin
                        n_in_payload = 1'b1;
                    end
                end
            end else begin
                // Payload byte: forward with its index.
                emit       = 1'b1;
                emit_valid = 1'b1;
                emit_byte  = s_axis_tdata;
                emit_idx   = r_pay_cnt;
                emit_last  = (idx_plus_one >= {1'b0, r_length});
                if (emit_last) begin
                    n_in_payload = 1'b0;
                    n_pay_cnt    = '0;
                    n_hdr_pos    = '0;
                end else begin
                    n_pay_cnt = idx_plus_one[IDX_W-1:0];
                end
            end
        end
    end

    // Output register loading.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid                = 1'b1;
            n_out_data.request_code    = n_request;
            n_out_data.payload_length  = n_length;
            n_out_data.x_bits          = n_x;
            n_out_data.y_bits          = n_y;
            n_out_data.z_bits          = n_z;
            n_out_data.payload_byte    = emit_byte;
            n_out_data.payload_index   = emit_idx;
            n_out_user                 = emit_valid;
            n_out_last                 = emit_last;
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_pos    <= '0;
            r_pay_cnt    <= '0;
            r_request    <= '0;
            r_length     <= '0;
            r_x          <= '0;
            r_y          <= '0;
            r_z          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_in_payload <= n_in_payload;
            r_hdr_pos    <= n_hdr_pos;
            r_pay_cnt    <= n_pay_cnt;
            r_request    <= n_request;
            r_length     <= n_length;
            r_x          <= n_x;
            r_y          <= n_y;
            r_z          <= n_z;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule

/* sim/length_prefixed_record_deframer_tb.sv */
// ----------------------------------------------------------------------------
// length_prefixed_record_deframer_tb: self-checking bench for the deframer
// Feeds byte requests into the slave side and compares each master-side
// result with a behavioural copy of the deframer. A short table of records
// runs first, then random records of mostly short lengths. Both sides idle
// at random.
// ----------------------------------------------------------------------------
module length_prefixed_record_deframer_tb;
    import lprd_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_BYTES   = 450;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned CALM_FIRST     = 200;
    localparam int unsigned CALM_LAST      = 500;
    localparam int unsigned IDLE_PERCENT   = 25;

    // One result as seen on the master side.
    typedef struct packed {
        t_result_data data;
        logic         byte_valid;
        logic         rec_last;
    } t_record_result;

    // One directed record; the typed result stands for its single result.
    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [BYTE_W-1:0] fill;
        logic [BYTE_W-1:0] stride;
        bit                typed;
        t_record_result    result;
    } t_record_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;   // [7:0] data_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [15:0] request_code, [31:16] payload_length, [63:32] x_bits,
    // [95:64] y_bits, [127:96] z_bits, [135:128] payload_byte,
    // [151:136] payload_index
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;        // [0] byte_valid
    logic                   m_axis_tlast;        // last

    // Directed records: empty record with all-ones fields, a one-byte record
    // with all-zero fields, and a short record left to the predictor.
    t_record_row record_table [3] = '{
        '{req: 16'hFFFF, len: 16'h0000, x: 32'hFFFF_FFFF, y: 32'hFFFF_FFFF,
          z: 32'hFFFF_FFFF, fill: 8'h00, stride: 8'h00, typed: 1'b1,
          result: '{data: '{payload_index: 16'h0000, payload_byte: 8'h00,
                            z_bits: 32'hFFFF_FFFF, y_bits: 32'hFFFF_FFFF,
                            x_bits: 32'hFFFF_FFFF, payload_length: 16'h0000,
                            request_code: 16'hFFFF},
                    byte_valid: 1'b0, rec_last: 1'b1}},
        '{req: 16'h0000, len: 16'h0001, x: 32'h0, y: 32'h0, z: 32'h0,
          fill: 8'hFF, stride: 8'h00, typed: 1'b1,
          result: '{data: '{payload_index: 16'h0000, payload_byte: 8'hFF,
                            z_bits: 32'h0, y_bits: 32'h0, x_bits: 32'h0,
                            payload_length: 16'h0001, request_code: 16'h0000},
                    byte_valid: 1'b1, rec_last: 1'b1}},
        '{req: 16'hA55A, len: 16'h0003, x: 32'h0123_4567, y: 32'h89AB_CDEF,
          z: 32'h8000_0001, fill: 8'h7F, stride: 8'h81, typed: 1'b0,
          result: '0}
    };

    // Predictor state: a copy of the deframer's header and counters.
    bit                hdr_in_payload = 1'b0;
    int unsigned       hdr_count = 0;
    logic [REQ_W-1:0]  cur_req = '0;
    logic [LEN_W-1:0]  cur_len = '0;
    logic [WORD_W-1:0] cur_x = '0;
    logic [WORD_W-1:0] cur_y = '0;
    logic [WORD_W-1:0] cur_z = '0;
    logic [IDX_W-1:0]  pay_count = '0;

    t_record_result pending_results [$];
    t_record_result fixed_results [$];
    int unsigned    mismatch_count = 0;
    int unsigned    cycle_count = 0;
    int unsigned    quiet_cycles = 0;

    length_prefixed_record_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Random idling, suspended over one window of cycles.
    function automatic bit take_break();
        if (cycle_count >= CALM_FIRST && cycle_count < CALM_LAST) begin
            return 1'b0;
        end
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    // Works out the result, if any, that one accepted byte causes.
    task automatic deframe_byte(input logic [7:0] b, output bit got,
                                output t_record_result r);
        int unsigned pos;
        got = 1'b0;
        r   = '0;
        if (!hdr_in_payload) begin
            pos = hdr_count;
            if (pos < OFS_LENGTH) begin
                cur_req[8*pos +: 8] = b;
            end else if (pos < OFS_X) begin
                cur_len[8*(pos-OFS_LENGTH) +: 8] = b;
            end else if (pos < OFS_Y) begin
                cur_x[8*(pos-OFS_X) +: 8] = b;
            end else if (pos < OFS_Z) begin
                cur_y[8*(pos-OFS_Y) +: 8] = b;
            end else begin
                cur_z[8*(pos-OFS_Z) +: 8] = b;
            end
            if (pos + 1 < HDR_BYTES) begin
                hdr_count = pos + 1;
            end else begin
                hdr_count = 0;
                pay_count = '0;
                if (cur_len == '0) begin
                    // An empty record closes on its final header byte.
                    got          = 1'b1;
                    r.byte_valid = 1'b0;
                    r.rec_last   = 1'b1;
                end else begin
                    hdr_in_payload = 1'b1;
                end
            end
        end else begin
            got                   = 1'b1;
            r.data.payload_byte   = b;
            r.data.payload_index  = pay_count;
            r.byte_valid          = 1'b1;
            r.rec_last            = (int'(pay_count) + 1 >= int'(cur_len));
            if (r.rec_last) begin
                hdr_in_payload = 1'b0;
                pay_count      = '0;
                hdr_count      = 0;
            end else begin
                pay_count = pay_count + 1'b1;
            end
        end
        if (got) begin
            r.data.request_code   = cur_req;
            r.data.payload_length = cur_len;
            r.data.x_bits         = cur_x;
            r.data.y_bits         = cur_y;
            r.data.z_bits         = cur_z;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, seen);
            mismatch_count++;
        end
    endtask

    // Offers one byte request and holds it until the block takes it.
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (take_break()) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Sends a header, little-endian, then its payload bytes.
    task automatic send_record(input logic [REQ_W-1:0] req,
                               input logic [LEN_W-1:0] len,
                               input logic [WORD_W-1:0] x,
                               input logic [WORD_W-1:0] y,
                               input logic [WORD_W-1:0] z,
                               input bit rnd,
                               input logic [BYTE_W-1:0] fill,
                               input logic [BYTE_W-1:0] stride);
        logic [8*HDR_BYTES-1:0] hdr;
        hdr = {z, y, x, len, req};
        for (int i = 0; i < HDR_BYTES; i++) begin
            send_byte(hdr[8*i +: 8]);
        end
        for (int i = 0; i < int'(len); i++) begin
            send_byte(rnd ? 8'($urandom) : 8'(fill + i * stride));
        end
    endtask

    // Sink side ready, with random stalls.
    always @(negedge i_clk) begin
        m_axis_tready = !take_break();
    end

    // Prediction on accepted bytes, checking of accepted results, watchdog.
    always @(posedge i_clk) begin : monitor
        bit             got;
        t_record_result r;
        t_record_result want;
        t_record_result seen;
        bit             moved;
        moved = 1'b0;
        if (i_rst_n) begin
            cycle_count++;
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                deframe_byte(s_axis_tdata, got, r);
                if (got) begin
                    if (fixed_results.size() > 0) begin
                        pending_results.push_back(fixed_results.pop_front());
                    end else begin
                        pending_results.push_back(r);
                    end
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved           = 1'b1;
                seen.data       = m_axis_tdata;
                seen.byte_valid = m_axis_tuser;
                seen.rec_last   = m_axis_tlast;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, seen);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("request_code", want.data.request_code,
                                seen.data.request_code);
                    check_field("payload_length", want.data.payload_length,
                                seen.data.payload_length);
                    check_field("x_bits", want.data.x_bits, seen.data.x_bits);
                    check_field("y_bits", want.data.y_bits, seen.data.y_bits);
                    check_field("z_bits", want.data.z_bits, seen.data.z_bits);
                    check_field("payload_byte", want.data.payload_byte,
                                seen.data.payload_byte);
                    check_field("payload_index", want.data.payload_index,
                                seen.data.payload_index);
                    check_field("byte_valid", want.byte_valid, seen.byte_valid);
                    check_field("last", want.rec_last, seen.rec_last);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Reset, directed records, then random records.
    initial begin
        int unsigned      sent;
        int unsigned      pick;
        logic [LEN_W-1:0] len;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (record_table[i]) begin
            if (record_table[i].typed) begin
                fixed_results.push_back(record_table[i].result);
            end
        end
        foreach (record_table[i]) begin
            send_record(record_table[i].req, record_table[i].len,
                        record_table[i].x, record_table[i].y, record_table[i].z,
                        1'b0, record_table[i].fill, record_table[i].stride);
        end

        // Mostly short payloads, some medium, a few long ones of up to 300 bytes.
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                len = LEN_W'($urandom_range(8));
            end else if (pick < 90) begin
                len = LEN_W'($urandom_range(40, 9));
            end else begin
                len = LEN_W'($urandom_range(300, 41));
            end
            send_record(REQ_W'($urandom), len, $urandom, $urandom, $urandom,
                        1'b1, 8'h00, 8'h00);
            sent += HDR_BYTES + len;
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
